// ===== hdl/mcpwm_pkg.sv =====
// Package for the multi-channel PWM register block.
// Holds register map constants, bus op codes and the per-channel command struct.
// No dependencies.
package mcpwm_pkg;

  localparam int CHANNELS_DEF   = 8;
  localparam int COUNT_BITS_DEF = 32;
  localparam int LEVEL_W        = 8;
  localparam int DATA_W         = 32;
  localparam int OFS_W          = 8;
  localparam int OP_W           = 2;
  localparam int IN_TDATA_W     = 48;
  localparam int OUT_TDATA_W    = 40;

  localparam int CH_STRIDE = 'h14;
  localparam int CTRL_OFS  = 'h08;
  localparam int ON_BASE   = 'hb0;
  localparam int ON_STRIDE = 'h04;
  localparam logic [DATA_W-1:0] RUN_MASK = 32'h0000_000b;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    REG_NONE = 2'd0,
    REG_OFF  = 2'd1,
    REG_CTRL = 2'd2,
    REG_ON   = 2'd3
  } reg_kind_t;

  typedef struct packed {
    logic tick;
    logic wr_off;
    logic wr_ctrl;
    logic wr_on;
  } ch_cmd_t;

endpackage

// ===== hdl/mcpwm_decode.sv =====
// Register offset decoder for the PWM register block.
// Maps a byte offset to register kind and channel index. Uses mcpwm_pkg.
module mcpwm_decode import mcpwm_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic [OFS_W-1:0] reg_offset,
  output reg_kind_t        kind,
  output logic [CH_W-1:0]  ch
);

  always_comb begin
    kind = REG_NONE;
    ch   = '0;
    for (int n = 0; n < CHANNELS; n++) begin
      if (32'(reg_offset) == 32'(n * CH_STRIDE)) begin
        kind = REG_OFF;
        ch   = CH_W'(n);
      end
      if (32'(reg_offset) == 32'(n * CH_STRIDE + CTRL_OFS)) begin
        kind = REG_CTRL;
        ch   = CH_W'(n);
      end
      if (32'(reg_offset) == 32'(ON_BASE + n * ON_STRIDE)) begin
        kind = REG_ON;
        ch   = CH_W'(n);
      end
    end
  end

endmodule

// ===== hdl/mcpwm_channel.sv =====
// One PWM channel: OFF/ON counts, control word, phase counter and output level.
// Driven by a command struct from the top level. Uses mcpwm_pkg.
module mcpwm_channel import mcpwm_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ch_cmd_t               cmd,
  input  logic [DATA_W-1:0]     wdata,
  output logic [COUNT_BITS-1:0] low_cnt,
  output logic [COUNT_BITS-1:0] high_cnt,
  output logic [DATA_W-1:0]     ctrl,
  output logic                  level_nxt
);

  localparam int PH_W = COUNT_BITS + 1;

  logic [COUNT_BITS-1:0] low_r, low_nxt;
  logic [COUNT_BITS-1:0] high_r, high_nxt;
  logic [DATA_W-1:0]     ctrl_r, ctrl_nxt;
  logic [PH_W-1:0]       phase_r, phase_nxt;
  logic                  level_r;
  logic [PH_W-1:0]       per_cur, per_new;
  logic [PH_W:0]         phase_inc;
  logic                  run_cur, run_new;

  always_comb begin
    low_nxt  = cmd.wr_off  ? wdata[COUNT_BITS-1:0] : low_r;
    high_nxt = cmd.wr_on   ? wdata[COUNT_BITS-1:0] : high_r;
    ctrl_nxt = cmd.wr_ctrl ? wdata : ctrl_r;

    per_cur   = {1'b0, low_r} + {1'b0, high_r};
    run_cur   = |(ctrl_r & RUN_MASK);
    phase_inc = {1'b0, phase_r} + 1'b1;

    phase_nxt = phase_r;
    level_nxt = level_r;
    if (cmd.tick && run_cur && (per_cur != '0)) begin
      level_nxt = (phase_r < {1'b0, high_r});
      phase_nxt = (phase_inc >= {1'b0, per_cur}) ? '0 : phase_inc[PH_W-1:0];
    end

    // disabled or zero-period channel parks at phase 0, output low
    per_new = {1'b0, low_nxt} + {1'b0, high_nxt};
    run_new = |(ctrl_nxt & RUN_MASK);
    if (!run_new || (per_new == '0)) begin
      phase_nxt = '0;
      level_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r   <= '0;
      high_r  <= '0;
      ctrl_r  <= '0;
      phase_r <= '0;
      level_r <= 1'b0;
    end else begin
      low_r   <= low_nxt;
      high_r  <= high_nxt;
      ctrl_r  <= ctrl_nxt;
      phase_r <= phase_nxt;
      level_r <= level_nxt;
    end
  end

  assign low_cnt  = low_r;
  assign high_cnt = high_r;
  assign ctrl     = ctrl_r;

endmodule

// ===== hdl/multi_channel_pwm_registers_top.sv =====
// Top level of the multi-channel PWM register block: stream in, stream out.
// Instantiates mcpwm_decode and mcpwm_channel. Uses mcpwm_pkg.
//
// Each input beat is a tick, a register read or a register write, and produces
// exactly one output beat carrying read data and all channel levels after that
// beat. The block takes one beat per clock unless the result register stalls; a beat
// passes through the input register, then the result register, to the output. All
// channel state is updated in the cycle a beat moves from the input register to
// the result register; the result register stalls the input register only when
// it holds an untaken beat, so a full-rate stream runs with out_tready high.
module multi_channel_pwm_registers_top import mcpwm_pkg::*; #(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [1:0] op, [9:2] reg_offset, [41:10] write_data, [47:42] unused
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [31:0] read_data, [39:32] pwm_levels
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic               in_valid_r;
  logic [OP_W-1:0]    op_r;
  logic [OFS_W-1:0]   ofs_r;
  logic [DATA_W-1:0]  wdata_r;
  logic               out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic               advance, fire;

  reg_kind_t          kind;
  logic [CH_W-1:0]    ch;
  ch_cmd_t            cmd [CHANNELS];
  logic [COUNT_BITS-1:0] low_cnt [CHANNELS];
  logic [COUNT_BITS-1:0] high_cnt [CHANNELS];
  logic [DATA_W-1:0]  ctrl [CHANNELS];
  logic [CHANNELS-1:0] levels;
  logic [DATA_W-1:0]  rdata;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      op_r    <= in_tdata[OP_W-1:0];
      ofs_r   <= in_tdata[OP_W+OFS_W-1:OP_W];
      wdata_r <= in_tdata[OP_W+OFS_W+DATA_W-1:OP_W+OFS_W];
    end
  end

  mcpwm_decode #(
    .CHANNELS (CHANNELS),
    .CH_W     (CH_W)
  ) u_decode (
    .reg_offset (ofs_r),
    .kind       (kind),
    .ch         (ch)
  );

  for (genvar n = 0; n < CHANNELS; n++) begin : g_ch
    logic sel;
    assign sel = fire && (ch == CH_W'(n));
    assign cmd[n].tick    = fire && (op_r == OP_TICK);
    assign cmd[n].wr_off  = sel && (op_r == OP_WRITE) && (kind == REG_OFF);
    assign cmd[n].wr_ctrl = sel && (op_r == OP_WRITE) && (kind == REG_CTRL);
    assign cmd[n].wr_on   = sel && (op_r == OP_WRITE) && (kind == REG_ON);

    mcpwm_channel #(
      .COUNT_BITS (COUNT_BITS)
    ) u_channel (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd[n]),
      .wdata     (wdata_r),
      .low_cnt   (low_cnt[n]),
      .high_cnt  (high_cnt[n]),
      .ctrl      (ctrl[n]),
      .level_nxt (levels[n])
    );
  end

  always_comb begin
    rdata = '0;
    if (op_r == OP_READ) begin
      unique case (kind)
        REG_OFF:  rdata = DATA_W'(low_cnt[ch]);
        REG_CTRL: rdata = ctrl[ch];
        REG_ON:   rdata = DATA_W'(high_cnt[ch]);
        default:  rdata = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {LEVEL_W'(levels), rdata};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hdl/mcpwm_checker.sv =====
// Port-level checker for the multi-channel PWM register block, bound to the top.
// Depends on mcpwm_pkg and multi_channel_pwm_registers_top.
module mcpwm_checker import mcpwm_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam logic [LEVEL_W-1:0] LEVEL_MASK = LEVEL_W'((1 << CHANNELS) - 1);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_unused_levels: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[DATA_W+LEVEL_W-1:DATA_W] & ~LEVEL_MASK) == '0))
    else $error("level set on a channel that does not exist");

endmodule

bind multi_channel_pwm_registers_top mcpwm_checker #(
  .CHANNELS (CHANNELS)
) u_mcpwm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
